@@ rtl/mst_pkg.sv @@
package mst_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int MAX_PIXELS = 65536;

    localparam int PIX_W    = 8;
    localparam int POS_W    = $clog2(MAX_PIXELS);
    localparam int SLOT_W   = $clog2(MAX_FRAMES);
    localparam int SIZE_W   = 5;
    localparam int THR_W    = 8;
    localparam int NULL_W   = 9;
    localparam int CIDX_W   = 2;
    localparam int CDATA_W  = 9;
    localparam int ROW_W    = MAX_FRAMES * PIX_W;
    localparam int GRP      = 4;
    localparam int NGRP     = MAX_FRAMES / GRP;
    localparam int GSUM_W   = PIX_W + $clog2(GRP);
    localparam int GCNT_W   = $clog2(GRP) + 1;
    localparam int SUM_W    = PIX_W + SLOT_W;
    localparam int CNT_W    = SLOT_W + 1;
    localparam int RECIP_SH = 17;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;

    localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(8);
    localparam logic [THR_W-1:0]  THR_RST  = THR_W'(10);
    localparam logic [NULL_W-1:0] NULL_RST = '1;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SIZE = 2'd0,
        CFG_THR  = 2'd1,
        CFG_NULL = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RMW,
        S_RED1,
        S_RED2,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
        logic [CNT_W-1:0] cnt;
    } t_stats;

    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            5'd1:    r = 18'd131072;
            5'd2:    r = 18'd65536;
            5'd3:    r = 18'd43691;
            5'd4:    r = 18'd32768;
            5'd5:    r = 18'd26215;
            5'd6:    r = 18'd21846;
            5'd7:    r = 18'd18725;
            5'd8:    r = 18'd16384;
            5'd9:    r = 18'd14564;
            5'd10:   r = 18'd13108;
            5'd11:   r = 18'd11916;
            5'd12:   r = 18'd10923;
            5'd13:   r = 18'd10083;
            5'd14:   r = 18'd9363;
            5'd15:   r = 18'd8739;
            5'd16:   r = 18'd8192;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/motion_sensitive_temporal_smoother.sv @@
// Each pixel is accepted while idle, its history row is read, merged and written
// back, reduced by a two-level min/max/sum tree and averaged by a reciprocal
// multiply before the result is registered to o_valid. A new pixel is accepted only
// after the previous result is loaded into the output register; a stalled output delays that.
// Reset (synchronous, active low) clears position, slot, fill count and
// config to defaults; history memory holds no reset and needs no clearing.
module motion_sensitive_temporal_smoother (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mst_pkg::PIX_W-1:0]       i_pixel,
    input  logic                            i_frame_end,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mst_pkg::PIX_W-1:0]       o_smoothed,
    output logic                            o_moving,
    output logic                            o_frame_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mst_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [mst_pkg::CDATA_W-1:0]     i_cfg_data
);

    mst_pkg::t_state                r_state;
    mst_pkg::t_state                n_state;

    logic [mst_pkg::SIZE_W-1:0]     r_size;
    logic [mst_pkg::THR_W-1:0]      r_thr;
    logic [mst_pkg::NULL_W-1:0]     r_null;
    logic [mst_pkg::POS_W-1:0]      r_pos;
    logic [mst_pkg::SLOT_W-1:0]     r_slot;
    logic [mst_pkg::SIZE_W-1:0]     r_filled;

    logic [mst_pkg::PIX_W-1:0]      r_cur_pix;
    logic                           r_cur_last;
    logic [mst_pkg::POS_W-1:0]      r_cur_pos;
    logic [mst_pkg::SLOT_W-1:0]     r_cur_slot;
    logic [mst_pkg::SIZE_W-1:0]     r_cur_active;

    logic                           r_out_valid;
    logic [mst_pkg::PIX_W-1:0]      r_out_smoothed;
    logic                           r_out_moving;
    logic                           r_out_last;

    logic                           in_xfer;
    logic                           cfg_xfer;
    logic                           out_xfer;
    logic                           load_out;
    logic                           wr_en;
    logic [mst_pkg::SIZE_W-1:0]     cfg_size;
    logic [mst_pkg::SIZE_W:0]       filled_inc;
    logic [mst_pkg::SIZE_W-1:0]     active;
    logic [mst_pkg::SLOT_W:0]       slot_inc;
    logic [mst_pkg::ROW_W-1:0]      rd_row;
    logic [mst_pkg::ROW_W-1:0]      merged;
    logic [mst_pkg::MAX_FRAMES-1:0] mask;
    mst_pkg::t_stats                stats;
    logic [mst_pkg::PIX_W-1:0]      mean;
    logic [mst_pkg::PIX_W-1:0]      spread;
    logic [mst_pkg::PIX_W-1:0]      res_smoothed;
    logic                           res_moving;

    assign in_xfer     = i_valid && o_ready;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign out_xfer    = r_out_valid && i_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mst_pkg::S_IDLE: if (i_valid) n_state = mst_pkg::S_RMW;
            mst_pkg::S_RMW:  n_state = mst_pkg::S_RED1;
            mst_pkg::S_RED1: n_state = mst_pkg::S_RED2;
            mst_pkg::S_RED2: n_state = mst_pkg::S_DIV;
            mst_pkg::S_DIV:  n_state = mst_pkg::S_DONE;
            mst_pkg::S_DONE: if (!r_out_valid || i_ready) n_state = mst_pkg::S_IDLE;
            default:         n_state = mst_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        wr_en    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            mst_pkg::S_IDLE: o_ready  = 1'b1;
            mst_pkg::S_RMW:  wr_en    = 1'b1;
            mst_pkg::S_DONE: load_out = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // clamp written size to 1..MAX_FRAMES
    always_comb begin
        if (i_cfg_data[mst_pkg::SIZE_W-1:0] == '0) begin
            cfg_size = mst_pkg::SIZE_W'(1);
        end else if (i_cfg_data[mst_pkg::SIZE_W-1:0] > mst_pkg::SIZE_W'(mst_pkg::MAX_FRAMES)) begin
            cfg_size = mst_pkg::SIZE_W'(mst_pkg::MAX_FRAMES);
        end else begin
            cfg_size = i_cfg_data[mst_pkg::SIZE_W-1:0];
        end
    end

    assign filled_inc = {1'b0, r_filled} + (mst_pkg::SIZE_W+1)'(1);
    assign active     = (filled_inc > {1'b0, r_size}) ? r_size : filled_inc[mst_pkg::SIZE_W-1:0];
    assign slot_inc   = {1'b0, r_slot} + (mst_pkg::SLOT_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= mst_pkg::SIZE_RST;
            r_thr    <= mst_pkg::THR_RST;
            r_null   <= mst_pkg::NULL_RST;
            r_pos    <= '0;
            r_slot   <= '0;
            r_filled <= '0;
        end else begin
            if (in_xfer) begin
                if (i_frame_end) begin
                    r_pos  <= '0;
                    r_slot <= ((mst_pkg::SIZE_W+1)'(slot_inc) >= (mst_pkg::SIZE_W+1)'(r_size))
                              ? '0 : slot_inc[mst_pkg::SLOT_W-1:0];
                    if (r_filled < r_size) r_filled <= filled_inc[mst_pkg::SIZE_W-1:0];
                end else begin
                    r_pos <= r_pos + mst_pkg::POS_W'(1);
                end
            end
            if (cfg_xfer) begin
                unique case (i_cfg_index)
                    mst_pkg::CFG_SIZE: begin
                        if (cfg_size != r_size) begin
                            r_size   <= cfg_size;
                            r_slot   <= '0;
                            r_filled <= '0;
                        end
                    end
                    mst_pkg::CFG_THR:  r_thr  <= i_cfg_data[mst_pkg::THR_W-1:0];
                    mst_pkg::CFG_NULL: r_null <= i_cfg_data[mst_pkg::NULL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cur_pix    <= i_pixel;
            r_cur_last   <= i_frame_end;
            r_cur_pos    <= r_pos;
            r_cur_slot   <= r_slot;
            r_cur_active <= active;
        end
    end

    mst_hist_mem u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_xfer),
        .i_rd_addr (r_pos),
        .o_rd_data (rd_row),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cur_pos),
        .i_wr_data (merged)
    );

    // insert pixel into its slot, mark non-null lanes inside the active window
    always_comb begin
        logic [mst_pkg::PIX_W-1:0] v;
        for (int t = 0; t < mst_pkg::MAX_FRAMES; t++) begin
            v = (mst_pkg::SLOT_W'(t) == r_cur_slot) ? r_cur_pix
                : rd_row[t*mst_pkg::PIX_W +: mst_pkg::PIX_W];
            merged[t*mst_pkg::PIX_W +: mst_pkg::PIX_W] = v;
            mask[t] = (mst_pkg::SIZE_W'(t) < r_cur_active) && ({1'b0, v} != r_null);
        end
    end

    mst_reduce u_reduce (
        .i_clk   (i_clk),
        .i_row   (merged),
        .i_mask  (mask),
        .o_stats (stats)
    );

    mst_mean u_mean (
        .i_clk  (i_clk),
        .i_sum  (stats.sum),
        .i_cnt  (stats.cnt),
        .o_mean (mean)
    );

    assign spread = stats.hi - stats.lo;

    always_comb begin
        res_moving = 1'b0;
        if (stats.cnt == '0) begin
            res_smoothed = r_null[mst_pkg::PIX_W-1:0];
        end else if (spread > r_thr) begin
            res_smoothed = r_cur_pix;
            res_moving   = 1'b1;
        end else begin
            res_smoothed = mean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_smoothed <= res_smoothed;
            r_out_moving   <= res_moving;
            r_out_last     <= r_cur_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_smoothed   = r_out_smoothed;
    assign o_moving     = r_out_moving;
    assign o_frame_last = r_out_last;

endmodule

@@ rtl/mst_hist_mem.sv @@
module mst_hist_mem (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [mst_pkg::POS_W-1:0]   i_rd_addr,
    output logic [mst_pkg::ROW_W-1:0]   o_rd_data,
    input  logic                        i_wr_en,
    input  logic [mst_pkg::POS_W-1:0]   i_wr_addr,
    input  logic [mst_pkg::ROW_W-1:0]   i_wr_data
);

    logic [mst_pkg::ROW_W-1:0] r_mem [mst_pkg::MAX_PIXELS];
    logic [mst_pkg::ROW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/mst_reduce.sv @@
module mst_reduce (
    input  logic                               i_clk,
    input  logic [mst_pkg::ROW_W-1:0]          i_row,
    input  logic [mst_pkg::MAX_FRAMES-1:0]     i_mask,
    output mst_pkg::t_stats                    o_stats
);

    logic [mst_pkg::ROW_W-1:0]      r_row;
    logic [mst_pkg::MAX_FRAMES-1:0] r_mask;
    logic [mst_pkg::GSUM_W-1:0]     r_gsum [mst_pkg::NGRP];
    logic [mst_pkg::PIX_W-1:0]      r_glo  [mst_pkg::NGRP];
    logic [mst_pkg::PIX_W-1:0]      r_ghi  [mst_pkg::NGRP];
    logic [mst_pkg::GCNT_W-1:0]     r_gcnt [mst_pkg::NGRP];
    logic [mst_pkg::GSUM_W-1:0]     n_gsum [mst_pkg::NGRP];
    logic [mst_pkg::PIX_W-1:0]      n_glo  [mst_pkg::NGRP];
    logic [mst_pkg::PIX_W-1:0]      n_ghi  [mst_pkg::NGRP];
    logic [mst_pkg::GCNT_W-1:0]     n_gcnt [mst_pkg::NGRP];
    mst_pkg::t_stats                r_stats;
    mst_pkg::t_stats                n_stats;

    always_ff @(posedge i_clk) begin
        r_row  <= i_row;
        r_mask <= i_mask;
    end

    always_comb begin
        logic [mst_pkg::PIX_W-1:0] v;
        for (int g = 0; g < mst_pkg::NGRP; g++) begin
            n_gsum[g] = '0;
            n_glo[g]  = '1;
            n_ghi[g]  = '0;
            n_gcnt[g] = '0;
            for (int k = 0; k < mst_pkg::GRP; k++) begin
                v = r_row[(g*mst_pkg::GRP+k)*mst_pkg::PIX_W +: mst_pkg::PIX_W];
                if (r_mask[g*mst_pkg::GRP+k]) begin
                    n_gsum[g] = n_gsum[g] + mst_pkg::GSUM_W'(v);
                    n_gcnt[g] = n_gcnt[g] + mst_pkg::GCNT_W'(1);
                    if (v < n_glo[g]) n_glo[g] = v;
                    if (v > n_ghi[g]) n_ghi[g] = v;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gsum <= n_gsum;
        r_glo  <= n_glo;
        r_ghi  <= n_ghi;
        r_gcnt <= n_gcnt;
    end

    always_comb begin
        n_stats.sum = '0;
        n_stats.lo  = '1;
        n_stats.hi  = '0;
        n_stats.cnt = '0;
        for (int g = 0; g < mst_pkg::NGRP; g++) begin
            n_stats.sum = n_stats.sum + mst_pkg::SUM_W'(r_gsum[g]);
            n_stats.cnt = n_stats.cnt + mst_pkg::CNT_W'(r_gcnt[g]);
            if (r_glo[g] < n_stats.lo) n_stats.lo = r_glo[g];
            if (r_ghi[g] > n_stats.hi) n_stats.hi = r_ghi[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_stats <= n_stats;
    end

    assign o_stats = r_stats;

endmodule

@@ rtl/mst_mean.sv @@
module mst_mean (
    input  logic                        i_clk,
    input  logic [mst_pkg::SUM_W-1:0]   i_sum,
    input  logic [mst_pkg::CNT_W-1:0]   i_cnt,
    output logic [mst_pkg::PIX_W-1:0]   o_mean
);

    logic [mst_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= mst_pkg::PROD_W'(i_sum) * mst_pkg::PROD_W'(mst_pkg::recip(i_cnt));
    end

    assign o_mean = r_prod[mst_pkg::RECIP_SH +: mst_pkg::PIX_W];

endmodule
